// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL, clocked on i_clk and quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// The same check with a message of the caller's choice.
`define ASSERT_CLK_MSG(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

// ===== rtl/dmac_pkg.sv =====
package dmac_pkg;

    localparam int CHANNELS    = 4;
    localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] OP_PROGRAM = 2'd0;
    localparam logic [1:0] OP_STOP    = 2'd1;
    localparam logic [1:0] OP_HBLANK  = 2'd2;
    localparam logic [1:0] OP_VBLANK  = 2'd3;

    localparam logic [1:0] TIM_NOW = 2'd0;
    localparam logic [1:0] TIM_VBL = 2'd1;
    localparam logic [1:0] TIM_HBL = 2'd2;

    localparam logic [1:0] MODE_INC    = 2'd0;
    localparam logic [1:0] MODE_DEC    = 2'd1;
    localparam logic [1:0] MODE_FIXED  = 2'd2;
    localparam logic [1:0] MODE_RELOAD = 2'd3;

    localparam int FLAG_ENABLE = 15;
    localparam int TIM_HI      = 13;
    localparam int TIM_LO      = 12;
    localparam int FLAG_WIDE   = 10;
    localparam int FLAG_REPEAT = 9;
    localparam int SMODE_HI    = 8;
    localparam int SMODE_LO    = 7;
    localparam int DMODE_HI    = 6;
    localparam int DMODE_LO    = 5;

    localparam logic [16:0] COUNT_DEFAULT = 17'h04000;
    localparam logic [16:0] COUNT_LONG    = 17'h10000;
    localparam logic [1:0]  LONG_CHANNEL  = 2'd3;

    localparam logic       KIND_DESC     = 1'b0;
    localparam logic       KIND_READBACK = 1'b1;

    typedef logic [15:0] t_flags;

endpackage

// ===== rtl/dma_channel_controller_core.sv =====
// Four-channel DMA channel controller core.
// Input channel (i_valid/o_ready) takes one operation per beat: program a
// channel, stop a channel, or an hblank or vblank trigger. The output channel
// (o_valid/i_ready) returns descriptors and control readbacks; o_last marks
// the final result of an operation, and a trigger that matches nothing
// returns no result at all.
// The block accepts an operation only when its sequencer is idle. A program
// or stop passes through accept and readback; programming an immediate
// channel passes through accept, source update, destination update and
// readback. A trigger scans the channels in turn, and each descriptor found
// passes through a source and a destination update on the single shared
// address adder; the scan ends early at the last descriptor.
// Results leave through one output register; while the receiver stalls, the
// sequencer holds before each result until that register is free, so no beat
// is lost. Reset clears all channel state, disarms every channel and empties
// the output register.
`include "assert_macros.svh"

module dma_channel_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_channel,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_target_address,
    input  logic [31:0] i_control_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [1:0]  o_channel_out,
    output logic [31:0] o_start_source,
    output logic [31:0] o_start_target,
    output logic [16:0] o_unit_count,
    output logic        o_wide,
    output logic [1:0]  o_source_mode,
    output logic [1:0]  o_target_mode,
    output logic [31:0] o_readback_control,
    output logic        o_last
);

    localparam int CH  = dmac_pkg::CHANNELS;
    localparam int IW  = dmac_pkg::IDX_W;
    localparam int CW  = dmac_pkg::CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SRC  = 3'd2;
    localparam logic [2:0] S_DST  = 3'd3;
    localparam logic [2:0] S_RB   = 3'd4;

    localparam logic [IW-1:0] IDX_LAST = IW'(CH - 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(dmac_pkg::MAX_RESULTS);
    localparam logic [CW-1:0] CNT_FIN  = CW'(dmac_pkg::MAX_RESULTS - 1);

    logic [31:0]            r_cur_src [CH];
    logic [31:0]            r_cur_tgt [CH];
    logic [31:0]            r_rld_src [CH];
    logic [31:0]            r_rld_tgt [CH];
    logic [16:0]            r_units   [CH];
    dmac_pkg::t_flags       r_flags   [CH];
    logic [CH-1:0]          r_armed;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_op;
    logic [31:0]   r_ctl;
    logic [IW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_idx, n_idx;
    logic [CH-1:0] r_mask, n_mask;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_last, n_last;

    logic          r_o_valid;
    logic          r_o_kind;
    logic [1:0]    r_o_channel;
    logic [31:0]   r_o_src;
    logic [31:0]   r_o_tgt;
    logic [16:0]   r_o_count;
    logic          r_o_wide;
    logic [1:0]    r_o_smode;
    logic [1:0]    r_o_dmode;
    logic [31:0]   r_o_rb;
    logic          r_o_last;

    logic             in_acc;
    logic             out_free;
    logic [IW-1:0]    in_idx;
    logic             in_ok;
    logic [1:0]       trig_tim;
    logic [CH-1:0]    match;
    dmac_pkg::t_flags sel_flags;
    logic             sel_wide;
    logic [1:0]       sel_smode;
    logic [1:0]       sel_dmode;
    logic [31:0]      align_mask;
    logic [31:0]      src_al;
    logic [31:0]      tgt_al;
    logic [31:0]      span;
    logic [31:0]      au_a;
    logic [1:0]       au_mode;
    logic [31:0]      au_res;
    logic [CH-1:0]    mask_taken;
    logic [31:0]      rb_value;
    logic [15:0]      in_flags;
    logic [16:0]      in_count;

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign in_idx   = IW'(i_channel);
    assign in_ok    = ({30'd0, i_channel} < 32'(CH));
    assign trig_tim = (i_operation == dmac_pkg::OP_HBLANK) ? dmac_pkg::TIM_HBL
                                                           : dmac_pkg::TIM_VBL;
    assign in_flags = i_control_word[31:16];

    always_comb begin
        if (i_control_word[15:0] != 16'd0) begin
            in_count = {1'b0, i_control_word[15:0]};
        end else if (i_channel == dmac_pkg::LONG_CHANNEL) begin
            in_count = dmac_pkg::COUNT_LONG;
        end else begin
            in_count = dmac_pkg::COUNT_DEFAULT;
        end
    end

    always_comb begin
        for (int i = 0; i < CH; i++) begin
            match[i] = r_armed[i]
                    && (r_flags[i][dmac_pkg::TIM_HI:dmac_pkg::TIM_LO] == trig_tim)
                    && (r_units[i] != 17'd0);
        end
    end

    assign sel_flags  = r_flags[r_cur];
    assign sel_wide   = sel_flags[dmac_pkg::FLAG_WIDE];
    assign sel_smode  = sel_flags[dmac_pkg::SMODE_HI:dmac_pkg::SMODE_LO];
    assign sel_dmode  = sel_flags[dmac_pkg::DMODE_HI:dmac_pkg::DMODE_LO];
    assign align_mask = sel_wide ? 32'hFFFF_FFFC : 32'hFFFF_FFFE;
    assign src_al     = r_cur_src[r_cur] & align_mask;
    assign tgt_al     = r_cur_tgt[r_cur] & align_mask;
    assign span       = sel_wide ? {13'd0, r_units[r_cur], 2'b00}
                                 : {14'd0, r_units[r_cur], 1'b0};
    assign au_a       = (r_state == S_SRC) ? src_al : tgt_al;
    assign au_mode    = (r_state == S_SRC) ? sel_smode : sel_dmode;

    always_comb begin
        case (au_mode)
            dmac_pkg::MODE_DEC:   au_res = au_a - span;
            dmac_pkg::MODE_FIXED: au_res = au_a;
            default:              au_res = au_a + span;
        endcase
    end

    always_comb begin
        mask_taken        = r_mask;
        mask_taken[r_idx] = 1'b0;
    end

    always_comb begin
        if (r_op == dmac_pkg::OP_STOP) begin
            rb_value = 32'd0;
        end else if (!r_ctl[16 + dmac_pkg::FLAG_ENABLE]
                     || r_ctl[16 + dmac_pkg::TIM_HI:16 + dmac_pkg::TIM_LO]
                        == dmac_pkg::TIM_NOW) begin
            rb_value = {1'b0, r_ctl[30:0]};
        end else begin
            rb_value = r_ctl;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_idx   = r_idx;
        n_mask  = r_mask;
        n_cnt   = r_cnt;
        n_last  = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cur  = in_idx;
                    n_idx  = '0;
                    n_cnt  = '0;
                    n_mask = match;
                    if (i_operation == dmac_pkg::OP_PROGRAM
                        || i_operation == dmac_pkg::OP_STOP) begin
                        if (!in_ok) begin
                            n_state = S_IDLE;
                        end else if (i_operation == dmac_pkg::OP_PROGRAM
                                     && in_flags[dmac_pkg::FLAG_ENABLE]
                                     && in_flags[dmac_pkg::TIM_HI:dmac_pkg::TIM_LO]
                                        == dmac_pkg::TIM_NOW) begin
                            n_last  = 1'b0;
                            n_state = S_SRC;
                        end else begin
                            n_state = S_RB;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_mask[r_idx] && r_cnt < CNT_MAX) begin
                    n_cur   = r_idx;
                    n_mask  = mask_taken;
                    n_last  = (mask_taken == '0) || (r_cnt == CNT_FIN);
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_SRC;
                end else if (r_idx == IDX_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_SRC: begin
                if (out_free) begin
                    n_state = S_DST;
                end
            end
            S_DST: begin
                if (r_op == dmac_pkg::OP_PROGRAM) begin
                    n_state = S_RB;
                end else if (r_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_SCAN;
                end
            end
            S_RB: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_idx   <= '0;
            r_mask  <= '0;
            r_cnt   <= '0;
            r_last  <= 1'b0;
            r_armed <= '0;
            for (int i = 0; i < CH; i++) begin
                r_cur_src[i] <= '0;
                r_cur_tgt[i] <= '0;
                r_rld_src[i] <= '0;
                r_rld_tgt[i] <= '0;
                r_units[i]   <= '0;
                r_flags[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_idx   <= n_idx;
            r_mask  <= n_mask;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            if (in_acc && in_ok) begin
                if (i_operation == dmac_pkg::OP_PROGRAM) begin
                    r_cur_src[in_idx] <= i_source_address;
                    r_rld_src[in_idx] <= i_source_address;
                    r_cur_tgt[in_idx] <= i_target_address;
                    r_rld_tgt[in_idx] <= i_target_address;
                    r_units[in_idx]   <= in_count;
                    r_flags[in_idx]   <= in_flags;
                    r_armed[in_idx]   <= in_flags[dmac_pkg::FLAG_ENABLE];
                end else if (i_operation == dmac_pkg::OP_STOP) begin
                    r_flags[in_idx] <= '0;
                    r_armed[in_idx] <= 1'b0;
                end
            end
            if (r_state == S_SRC && out_free) begin
                if (sel_flags[dmac_pkg::FLAG_REPEAT]
                    && sel_smode == dmac_pkg::MODE_FIXED) begin
                    r_cur_src[r_cur] <= r_rld_src[r_cur];
                end else begin
                    r_cur_src[r_cur] <= au_res;
                end
            end
            if (r_state == S_DST) begin
                if (!sel_flags[dmac_pkg::FLAG_REPEAT]) begin
                    r_cur_tgt[r_cur] <= au_res;
                    r_armed[r_cur]   <= 1'b0;
                end else if (sel_dmode == dmac_pkg::MODE_RELOAD) begin
                    r_cur_tgt[r_cur] <= r_rld_tgt[r_cur];
                end else begin
                    r_cur_tgt[r_cur] <= au_res;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_operation;
            r_ctl <= i_control_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == S_SRC || r_state == S_RB) && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SRC && out_free) begin
            r_o_kind    <= dmac_pkg::KIND_DESC;
            r_o_channel <= 2'(r_cur);
            r_o_src     <= src_al;
            r_o_tgt     <= tgt_al;
            r_o_count   <= r_units[r_cur];
            r_o_wide    <= sel_wide;
            r_o_smode   <= sel_smode;
            r_o_dmode   <= sel_dmode;
            r_o_rb      <= 32'd0;
            r_o_last    <= r_last;
        end else if (r_state == S_RB && out_free) begin
            r_o_kind    <= dmac_pkg::KIND_READBACK;
            r_o_channel <= 2'(r_cur);
            r_o_src     <= r_rld_src[r_cur];
            r_o_tgt     <= r_rld_tgt[r_cur];
            r_o_count   <= r_units[r_cur];
            r_o_wide    <= sel_wide;
            r_o_smode   <= sel_smode;
            r_o_dmode   <= sel_dmode;
            r_o_rb      <= rb_value;
            r_o_last    <= 1'b1;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_kind             = r_o_kind;
    assign o_channel_out      = r_o_channel;
    assign o_start_source     = r_o_src;
    assign o_start_target     = r_o_tgt;
    assign o_unit_count       = r_o_count;
    assign o_wide             = r_o_wide;
    assign o_source_mode      = r_o_smode;
    assign o_target_mode      = r_o_dmode;
    assign o_readback_control = r_o_rb;
    assign o_last             = r_o_last;

    `ASSERT_CLK_MSG(a_readback_is_last, (o_valid && o_kind) |-> o_last,
                    "readback beat without last")
    `ASSERT_CLK_MSG(a_desc_has_units, (o_valid && !o_kind) |-> (o_unit_count != 17'd0),
                    "descriptor beat with zero units")
    `ASSERT_CLK(a_busy_after_accept, (i_valid && o_ready) |=> !o_ready)

endmodule

// ===== bench/tb_dma_channel_controller_core.sv =====
module tb_dma_channel_controller_core;
    import dmac_pkg::*;

    localparam logic [1:0] TIM_SPECIAL = 2'd3;
    localparam int RANDOM_ITEMS = 320;
    localparam int TAIL_CYCLES = 24;

    typedef struct packed {
        logic        kind;
        logic [1:0]  chan;
        logic [31:0] src;
        logic [31:0] dst;
        logic [16:0] count;
        logic        wide;
        logic [1:0]  smode;
        logic [1:0]  dmode;
        logic [31:0] rbctl;
        logic        last;
    } dma_result_t;

    class dma_scoreboard;
        logic [31:0] cur_src [CHANNELS];
        logic [31:0] cur_dst [CHANNELS];
        logic [31:0] rl_src [CHANNELS];
        logic [31:0] rl_dst [CHANNELS];
        logic [16:0] units [CHANNELS];
        t_flags      flags [CHANNELS];
        bit          armed [CHANNELS];
        dma_result_t expected_q[$];
        int          errors;
        int          n_desc;
        int          n_readback;

        function new();
            for (int i = 0; i < CHANNELS; i++) begin
                cur_src[i] = '0;
                cur_dst[i] = '0;
                rl_src[i] = '0;
                rl_dst[i] = '0;
                units[i] = '0;
                flags[i] = '0;
                armed[i] = 1'b0;
            end
            errors = 0;
            n_desc = 0;
            n_readback = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function dma_result_t make_result(logic kind, logic [1:0] ch, logic [31:0] s,
                                          logic [31:0] t, logic [16:0] cnt, t_flags f,
                                          logic [31:0] rb);
            dma_result_t r;
            r.kind = kind;
            r.chan = ch;
            r.src = s;
            r.dst = t;
            r.count = cnt;
            r.wide = f[FLAG_WIDE];
            r.smode = f[SMODE_HI:SMODE_LO];
            r.dmode = f[DMODE_HI:DMODE_LO];
            r.rbctl = rb;
            r.last = 1'b0;
            return r;
        endfunction

        function logic [31:0] step_address(logic [31:0] start, logic [1:0] mode,
                                           logic [31:0] span);
            if (mode == MODE_DEC)
                return start - span;
            if (mode == MODE_FIXED)
                return start;
            return start + span;
        endfunction

        // Queues the descriptor of one channel and moves its addresses on.
        function int fire_channel(int c);
            t_flags      f;
            logic [31:0] unit_bytes;
            logic [31:0] s;
            logic [31:0] t;
            logic [31:0] span;
            logic [1:0]  sm;
            logic [1:0]  dm;
            f = flags[c];
            if (units[c] == 17'd0)
                return 0;
            unit_bytes = f[FLAG_WIDE] ? 32'd4 : 32'd2;
            s = cur_src[c] & ~(unit_bytes - 32'd1);
            t = cur_dst[c] & ~(unit_bytes - 32'd1);
            sm = f[SMODE_HI:SMODE_LO];
            dm = f[DMODE_HI:DMODE_LO];
            expected_q.push_back(make_result(KIND_DESC, 2'(c), s, t, units[c], f, 32'd0));
            span = {15'd0, units[c]} * unit_bytes;
            if (f[FLAG_REPEAT]) begin
                cur_src[c] = (sm == MODE_FIXED) ? rl_src[c] : step_address(s, sm, span);
                cur_dst[c] = (dm == MODE_RELOAD) ? rl_dst[c] : step_address(t, dm, span);
            end else begin
                cur_src[c] = step_address(s, sm, span);
                cur_dst[c] = step_address(t, dm, span);
                armed[c] = 1'b0;
            end
            return 1;
        endfunction

        function void note_operation(logic [1:0] op, logic [1:0] ch, logic [31:0] src,
                                     logic [31:0] dst, logic [31:0] ctl);
            int          c;
            int          first;
            int          produced;
            t_flags      f;
            logic [31:0] rb;
            logic [1:0]  timing;
            c = int'(ch);
            first = expected_q.size();
            if (op == OP_PROGRAM || op == OP_STOP) begin
                if (c >= CHANNELS)
                    return;
                if (op == OP_PROGRAM) begin
                    f = ctl[31:16];
                    cur_src[c] = src;
                    rl_src[c] = src;
                    cur_dst[c] = dst;
                    rl_dst[c] = dst;
                    if (ctl[15:0] != 16'd0)
                        units[c] = {1'b0, ctl[15:0]};
                    else
                        units[c] = (ch == LONG_CHANNEL) ? COUNT_LONG : COUNT_DEFAULT;
                    flags[c] = f;
                    if (!f[FLAG_ENABLE]) begin
                        armed[c] = 1'b0;
                        rb = ctl & ~(32'd1 << (FLAG_ENABLE + 16));
                    end else begin
                        armed[c] = 1'b1;
                        if (f[TIM_HI:TIM_LO] == TIM_NOW) begin
                            void'(fire_channel(c));
                            rb = ctl & ~(32'd1 << (FLAG_ENABLE + 16));
                        end else begin
                            rb = ctl;
                        end
                    end
                end else begin
                    armed[c] = 1'b0;
                    flags[c] = '0;
                    rb = 32'd0;
                end
                expected_q.push_back(make_result(KIND_READBACK, ch, rl_src[c], rl_dst[c],
                                                 units[c], flags[c], rb));
            end else begin
                timing = (op == OP_HBLANK) ? TIM_HBL : TIM_VBL;
                produced = 0;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (produced < MAX_RESULTS && armed[i]
                            && flags[i][TIM_HI:TIM_LO] == timing)
                        produced += fire_channel(i);
                end
            end
            if (expected_q.size() > first)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: mismatch on %s: expected %h, actual %h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(dma_result_t got);
            dma_result_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: kind %0d channel %0d, expected none",
                         $time, got.kind, got.chan);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (exp_r.kind == KIND_DESC)
                n_desc++;
            else
                n_readback++;
            compare("kind", 32'(exp_r.kind), 32'(got.kind));
            compare("channel_out", 32'(exp_r.chan), 32'(got.chan));
            compare("start_source", exp_r.src, got.src);
            compare("start_target", exp_r.dst, got.dst);
            compare("unit_count", 32'(exp_r.count), 32'(got.count));
            compare("wide", 32'(exp_r.wide), 32'(got.wide));
            compare("source_mode", 32'(exp_r.smode), 32'(got.smode));
            compare("target_mode", 32'(exp_r.dmode), 32'(got.dmode));
            compare("readback_control", exp_r.rbctl, got.rbctl);
            compare("last", 32'(exp_r.last), 32'(got.last));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = '0;
    logic [1:0]  i_channel = '0;
    logic [31:0] i_source_address = '0;
    logic [31:0] i_target_address = '0;
    logic [31:0] i_control_word = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_kind;
    logic [1:0]  o_channel_out;
    logic [31:0] o_start_source;
    logic [31:0] o_start_target;
    logic [16:0] o_unit_count;
    logic        o_wide;
    logic [1:0]  o_source_mode;
    logic [1:0]  o_target_mode;
    logic [31:0] o_readback_control;
    logic        o_last;

    dma_scoreboard sb;
    int            ops_sent = 0;
    int            burst_left = 0;
    logic [15:0]   ready_pattern = 16'hFFFF;
    int unsigned   ready_phase = 0;

    dma_channel_controller_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_operation        (i_operation),
        .i_channel          (i_channel),
        .i_source_address   (i_source_address),
        .i_target_address   (i_target_address),
        .i_control_word     (i_control_word),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_channel_out      (o_channel_out),
        .o_start_source     (o_start_source),
        .o_start_target     (o_start_target),
        .o_unit_count       (o_unit_count),
        .o_wide             (o_wide),
        .o_source_mode      (o_source_mode),
        .o_target_mode      (o_target_mode),
        .o_readback_control (o_readback_control),
        .o_last             (o_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] make_control(bit en, logic [1:0] tim, bit wide, bit rpt,
                                                 logic [1:0] sm, logic [1:0] dm,
                                                 logic [15:0] cnt);
        t_flags f;
        f = '0;
        f[FLAG_ENABLE] = en;
        f[TIM_HI:TIM_LO] = tim;
        f[FLAG_WIDE] = wide;
        f[FLAG_REPEAT] = rpt;
        f[SMODE_HI:SMODE_LO] = sm;
        f[DMODE_HI:DMODE_LO] = dm;
        return {f, cnt};
    endfunction

    // One beat on the input channel, followed now and then by an idle gap.
    task automatic send_item(logic [1:0] op, logic [1:0] ch, logic [31:0] src,
                             logic [31:0] dst, logic [31:0] ctl);
        int gap;
        i_valid <= 1'b1;
        i_operation <= op;
        i_channel <= ch;
        i_source_address <= src;
        i_target_address <= dst;
        i_control_word <= ctl;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_operation(op, ch, src, dst, ctl);
        ops_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(0, 10);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_trigger(logic [1:0] op);
        send_item(op, 2'($urandom), $urandom, $urandom, $urandom);
    endtask

    task automatic send_random_item();
        int          r;
        int          w;
        logic [1:0]  tim;
        logic [15:0] cnt;
        logic [31:0] ctl;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            send_item(2'($urandom), 2'($urandom), $urandom, $urandom, $urandom);
        end else if (r < 42) begin
            w = $urandom_range(0, 99);
            if (w < 35)
                tim = TIM_HBL;
            else if (w < 70)
                tim = TIM_VBL;
            else if (w < 90)
                tim = TIM_NOW;
            else
                tim = TIM_SPECIAL;
            w = $urandom_range(0, 99);
            if (w < 50)
                cnt = 16'($urandom_range(1, 16));
            else if (w < 65)
                cnt = 16'd0;
            else
                cnt = 16'($urandom);
            ctl = $urandom;
            ctl[FLAG_ENABLE + 16] = ($urandom_range(0, 99) < 85);
            ctl[TIM_HI + 16:TIM_LO + 16] = tim;
            ctl[15:0] = cnt;
            send_item(OP_PROGRAM, 2'($urandom), $urandom, $urandom, ctl);
        end else if (r < 50) begin
            send_item(OP_STOP, 2'($urandom), $urandom, $urandom, $urandom);
        end else begin
            send_trigger(($urandom_range(0, 1) == 0) ? OP_HBLANK : OP_VBLANK);
        end
    endtask

    // Receiver: takes results and stalls on a random pattern that it redraws periodically.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_kind, o_channel_out, o_start_source, o_start_target,
                             o_unit_count, o_wide, o_source_mode, o_target_mode,
                             o_readback_control, o_last});
        ready_phase <= ready_phase + 1;
        if (ready_phase % 48 == 47)
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
        i_ready <= ready_pattern[ready_phase[3:0]];
    end

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_trigger(OP_HBLANK);
        send_item(OP_PROGRAM, 2'd0, 32'hFFFF_FFFF, 32'h0000_0001,
                  make_control(1, TIM_NOW, 0, 0, MODE_INC, MODE_INC, 16'd0));
        send_item(OP_PROGRAM, 2'd3, 32'h0000_0003, 32'h0000_0006,
                  make_control(1, TIM_NOW, 1, 0, MODE_DEC, MODE_DEC, 16'd0));
        send_item(OP_PROGRAM, 2'd1, 32'h1234_5677, 32'h89AB_CDEF,
                  make_control(0, TIM_HBL, 1, 1, MODE_FIXED, MODE_RELOAD, 16'd9));
        send_item(OP_PROGRAM, 2'd1, 32'hFFFF_FFF0, 32'h8000_0002,
                  make_control(1, TIM_HBL, 1, 1, MODE_FIXED, MODE_RELOAD, 16'hFFFF));
        send_item(OP_PROGRAM, 2'd2, 32'h0000_0000, 32'hFFFF_FFFE,
                  make_control(1, TIM_VBL, 0, 1, MODE_DEC, MODE_INC, 16'd1));
        send_item(OP_PROGRAM, 2'd0, 32'h4000_0000, 32'h5000_0000,
                  make_control(1, TIM_SPECIAL, 0, 1, MODE_INC, MODE_INC, 16'd4));
        send_trigger(OP_HBLANK);
        send_trigger(OP_HBLANK);
        send_trigger(OP_VBLANK);
        send_trigger(OP_VBLANK);
        send_item(OP_PROGRAM, 2'd3, 32'h0000_1001, 32'h0000_2003,
                  make_control(1, TIM_HBL, 0, 0, MODE_FIXED, MODE_FIXED, 16'd5));
        send_item(OP_PROGRAM, 2'd0, 32'hFFFF_FFFC, 32'h0000_0010,
                  make_control(1, TIM_HBL, 1, 1, MODE_RELOAD, MODE_FIXED, 16'd3));
        send_item(OP_PROGRAM, 2'd2, 32'h0000_0100, 32'h0000_0200,
                  make_control(1, TIM_HBL, 0, 1, MODE_INC, MODE_DEC, 16'd2));
        send_trigger(OP_HBLANK);
        send_trigger(OP_HBLANK);
        send_item(OP_STOP, 2'd1, $urandom, $urandom, $urandom);
        send_trigger(OP_HBLANK);
        send_item(OP_STOP, 2'd3, $urandom, $urandom, $urandom);
        send_item(OP_PROGRAM, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_PROGRAM, 2'd2, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_trigger(OP_VBLANK);
        send_item(OP_STOP, 2'd0, $urandom, $urandom, $urandom);
        send_item(OP_STOP, 2'd2, $urandom, $urandom, $urandom);

        repeat (RANDOM_ITEMS) send_random_item();

        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d operations; checked %0d transfer descriptors and %0d readbacks.",
                 ops_sent, sb.n_desc, sb.n_readback);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d results still outstanding.", sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dmac_pkg.sv
rtl/dma_channel_controller_core.sv
bench/tb_dma_channel_controller_core.sv
